/* src/mvm_pkg.sv */
package mvm_pkg;

    localparam int VAL_W  = 16;   // item_value, Q8.8
    localparam int SUM_W  = 35;   // product_sum, Q19.16
    localparam int IDX_W  = 3;    // row_index, col_index, out_row
    localparam int SIZE_W = 4;    // rows_in_use, cols_in_use

    localparam int DEF_MAX_ROWS    = 8;
    localparam int DEF_MAX_COLS    = 8;
    localparam int DEF_ENTRY_WIDTH = 16;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);
    localparam logic [SIZE_W-1:0] COUNT_MAX  = '1;

    // configuration register indexes
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // input operation codes
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_ELEMENT = 1'b1;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DRAIN,
        ST_ERR
    } mvm_state_t;

    typedef struct packed {
        logic mac_en;   // add the registered product
        logic shift;    // take the neighbor's sum
        logic clear;    // zero the sum
    } mvm_cell_ctrl_t;

    // zero reads as one, anything above the limit reads as the limit
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input int unsigned max_v);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (32'(v) > max_v)
            r = SIZE_W'(max_v);
        else
            r = v;
        return r;
    endfunction

endpackage

/* src/mvm_ram.sv */
module mvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/mvm_cell.sv */
module mvm_cell #(
    parameter int CELL_INDEX  = 0,
    parameter int MAX_COLS    = mvm_pkg::DEF_MAX_COLS,
    parameter int ENTRY_WIDTH = mvm_pkg::DEF_ENTRY_WIDTH,
    localparam int COL_AW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mvm_pkg::mvm_cell_ctrl_t           ctrl,
    input  logic                              wr_en,
    input  logic [mvm_pkg::IDX_W-1:0]         wr_row,
    input  logic [COL_AW-1:0]                 wr_col,
    input  logic [ENTRY_WIDTH-1:0]            wr_data,
    input  logic                              rd_en,
    input  logic [COL_AW-1:0]                 rd_col,
    input  logic signed [mvm_pkg::VAL_W-1:0]  vec_value,
    input  logic [mvm_pkg::SIZE_W-1:0]        rows,
    input  logic [mvm_pkg::SUM_W-1:0]         acc_in,
    output logic [mvm_pkg::SUM_W-1:0]         acc_out
);

    localparam int PROD_W = ENTRY_WIDTH + mvm_pkg::VAL_W;
    localparam int EXT_W  = (PROD_W > mvm_pkg::SUM_W) ? PROD_W : mvm_pkg::SUM_W;

    logic                            row_hit;
    logic                            in_use;
    logic [ENTRY_WIDTH-1:0]          entry;
    logic signed [PROD_W-1:0]        prod_reg;
    logic signed [PROD_W-1:0]        prod_next;
    logic signed [EXT_W-1:0]         prod_ext;
    logic [mvm_pkg::SUM_W-1:0]       acc_reg;
    logic [mvm_pkg::SUM_W-1:0]       acc_next;

    assign row_hit = (32'(wr_row) == CELL_INDEX);
    assign in_use  = (CELL_INDEX < 32'(rows));

    mvm_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (MAX_COLS)
    ) u_row_ram (
        .clk   (clk),
        .we    (wr_en && row_hit),
        .waddr (wr_col),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_col),
        .rdata (entry)
    );

    assign prod_next = $signed(entry) * vec_value;
    assign prod_ext  = EXT_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
            acc_next = '0;
        else if (ctrl.shift)
            acc_next = acc_in;
        else if (ctrl.mac_en && in_use)
            acc_next = acc_reg + prod_ext[mvm_pkg::SUM_W-1:0];   // wraps at 35 bits
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    assign acc_out = acc_reg;

endmodule

/* src/matrix_vector_multiply_core.sv */
// Each element reads every row store into s1 with its value, forms products in s2, then adds
// into each row sum in use. After the last element leaves s2, rows drain from row 0, one per
// cycle while out_stall is low; the input stalls until the last row or error beat is loaded.
// Throughput: one matrix write or vector element per cycle while in_stall is low, set by one
// MAC per row cell. Reset (rst_n low, async): row sums and element count cleared, both size
// registers at 8; the matrix store keeps no reset and must be written before use.
module matrix_vector_multiply_core #(
    parameter int MAX_ROWS    = mvm_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = mvm_pkg::DEF_MAX_COLS,
    parameter int ENTRY_WIDTH = mvm_pkg::DEF_ENTRY_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [mvm_pkg::SIZE_W-1:0]         cfg_data,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               operation,
    input  logic [mvm_pkg::IDX_W-1:0]          row_index,
    input  logic [mvm_pkg::IDX_W-1:0]          col_index,
    input  logic signed [mvm_pkg::VAL_W-1:0]   item_value,
    input  logic                               vector_last,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [mvm_pkg::IDX_W-1:0]          out_row,
    output logic signed [mvm_pkg::SUM_W-1:0]   product_sum,
    output logic                               result_last,
    output logic                               size_error
);

    localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // configuration
    logic [mvm_pkg::SIZE_W-1:0] rows_cfg_reg;
    logic [mvm_pkg::SIZE_W-1:0] cols_cfg_reg;
    logic [mvm_pkg::SIZE_W-1:0] rows;
    logic [mvm_pkg::SIZE_W-1:0] cols;

    // input side
    logic                        in_acc;
    logic                        elem_acc;
    logic                        wr_en;
    logic [mvm_pkg::SIZE_W-1:0]  count_reg;
    logic [mvm_pkg::SIZE_W-1:0]  count_next;
    logic [mvm_pkg::SIZE_W-1:0]  count_total;
    logic                        add_en;

    // element pipeline
    logic                        s1_valid_reg, s1_add_reg, s1_last_reg, s1_err_reg;
    logic                        s2_valid_reg, s2_add_reg, s2_last_reg, s2_err_reg;
    logic signed [mvm_pkg::VAL_W-1:0] s1_value_reg;

    // control
    mvm_pkg::mvm_state_t         state_reg;
    mvm_pkg::mvm_state_t         state_next;
    mvm_pkg::mvm_cell_ctrl_t     cell_ctrl;
    logic                        out_load;
    logic                        drain_last;
    logic [mvm_pkg::SIZE_W-1:0]  drain_cnt_reg;
    logic [mvm_pkg::SIZE_W-1:0]  drain_cnt_next;

    // output register
    logic                        out_valid_reg;
    logic [mvm_pkg::IDX_W-1:0]   out_row_reg;
    logic [mvm_pkg::SUM_W-1:0]   product_sum_reg;
    logic                        result_last_reg;
    logic                        size_error_reg;

    logic [mvm_pkg::SUM_W-1:0]   sum_chain [MAX_ROWS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= mvm_pkg::SIZE_RESET;
            cols_cfg_reg <= mvm_pkg::SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mvm_pkg::REG_ROWS: rows_cfg_reg <= cfg_data;
                mvm_pkg::REG_COLS: cols_cfg_reg <= cfg_data;
                default:           rows_cfg_reg <= rows_cfg_reg;
            endcase
        end
    end

    assign rows = mvm_pkg::clamp_size(rows_cfg_reg, MAX_ROWS);
    assign cols = mvm_pkg::clamp_size(cols_cfg_reg, MAX_COLS);

    // hold the input from a last element until its results are out
    assign in_stall = (state_reg != mvm_pkg::ST_RUN)
                   || (s1_valid_reg && s1_last_reg)
                   || (s2_valid_reg && s2_last_reg);
    assign in_acc   = in_valid && !in_stall;
    assign elem_acc = in_acc && (operation == mvm_pkg::OP_ELEMENT);
    assign wr_en    = in_acc && (operation == mvm_pkg::OP_WRITE)
                   && (32'(row_index) < MAX_ROWS) && (32'(col_index) < MAX_COLS);

    assign add_en      = (count_reg < cols) && (32'(count_reg) < MAX_COLS);
    assign count_total = (count_reg == mvm_pkg::COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign count_next  = vector_last ? '0 : count_total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s1_add_reg   <= 1'b0;
            s1_last_reg  <= 1'b0;
            s1_err_reg   <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_add_reg   <= 1'b0;
            s2_last_reg  <= 1'b0;
            s2_err_reg   <= 1'b0;
        end
        else
        begin
            if (elem_acc)
            begin
                count_reg <= count_next;
            end
            s1_valid_reg <= elem_acc;
            s1_add_reg   <= add_en;
            s1_last_reg  <= vector_last;
            s1_err_reg   <= vector_last && (count_total != cols);
            s2_valid_reg <= s1_valid_reg;
            s2_add_reg   <= s1_add_reg;
            s2_last_reg  <= s1_last_reg;
            s2_err_reg   <= s1_err_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_value_reg <= item_value;
    end

    // result sequencer
    assign out_load   = ((state_reg == mvm_pkg::ST_DRAIN) || (state_reg == mvm_pkg::ST_ERR))
                     && (!out_valid_reg || !out_stall);
    assign drain_last = (drain_cnt_reg == rows - 1'b1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mvm_pkg::ST_RUN:
            begin
                if (s2_valid_reg && s2_last_reg)
                    state_next = s2_err_reg ? mvm_pkg::ST_ERR : mvm_pkg::ST_DRAIN;
            end
            mvm_pkg::ST_DRAIN:
            begin
                if (out_load && drain_last)
                    state_next = mvm_pkg::ST_RUN;
            end
            mvm_pkg::ST_ERR:
            begin
                if (out_load)
                    state_next = mvm_pkg::ST_RUN;
            end
            default:
                state_next = mvm_pkg::ST_RUN;
        endcase
    end

    always_comb
    begin
        cell_ctrl.mac_en = s2_valid_reg && s2_add_reg;
        cell_ctrl.shift  = 1'b0;
        cell_ctrl.clear  = 1'b0;
        drain_cnt_next   = drain_cnt_reg;
        unique case (state_reg)
            mvm_pkg::ST_RUN:
            begin
                drain_cnt_next = '0;
            end
            mvm_pkg::ST_DRAIN:
            begin
                cell_ctrl.shift = out_load;
                cell_ctrl.clear = out_load && drain_last;   // also wipes rows past rows_in_use
                if (out_load)
                    drain_cnt_next = drain_cnt_reg + 1'b1;
            end
            mvm_pkg::ST_ERR:
            begin
                cell_ctrl.clear = out_load;
            end
            default:
            begin
                drain_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mvm_pkg::ST_RUN;
            drain_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            drain_cnt_reg <= drain_cnt_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (state_reg == mvm_pkg::ST_ERR)
            begin
                out_row_reg     <= '0;
                product_sum_reg <= '0;
                result_last_reg <= 1'b1;
                size_error_reg  <= 1'b1;
            end
            else
            begin
                out_row_reg     <= drain_cnt_reg[mvm_pkg::IDX_W-1:0];
                product_sum_reg <= sum_chain[0];
                result_last_reg <= drain_last;
                size_error_reg  <= 1'b0;
            end
        end
    end

    // row cells; sums move toward cell 0 while draining
    assign sum_chain[MAX_ROWS] = '0;

    for (genvar i = 0; i < MAX_ROWS; i++)
    begin : g_cell
        mvm_cell #(
            .CELL_INDEX  (i),
            .MAX_COLS    (MAX_COLS),
            .ENTRY_WIDTH (ENTRY_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .wr_en     (wr_en),
            .wr_row    (row_index),
            .wr_col    (COL_AW'(col_index)),
            .wr_data   (ENTRY_WIDTH'(item_value)),
            .rd_en     (elem_acc),
            .rd_col    (COL_AW'(count_reg)),
            .vec_value (s1_value_reg),
            .rows      (rows),
            .acc_in    (sum_chain[i+1]),
            .acc_out   (sum_chain[i])
        );
    end

    assign out_valid   = out_valid_reg;
    assign out_row     = out_row_reg;
    assign product_sum = product_sum_reg;
    assign result_last = result_last_reg;
    assign size_error  = size_error_reg;

endmodule

/* src/mvm_checker.sv */
module mvm_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               operation,
    input logic                               vector_last,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic [mvm_pkg::IDX_W-1:0]          out_row,
    input logic signed [mvm_pkg::SUM_W-1:0]   product_sum,
    input logic                               result_last,
    input logic                               size_error
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(product_sum) && $stable(out_row))
    else $error("result beat changed under stall");

    // an error beat is a lone, empty, final result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && size_error |-> result_last && (product_sum == '0) && (out_row == '0))
    else $error("malformed size error beat");

    // after the last element is taken the input stays stalled while it passes s1 and s2
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation && vector_last |=> in_stall ##1 in_stall)
    else $error("input taken while results pending");

    // a result beat right after a taken final beat is row 0
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && result_last |=> !out_valid || (out_row == '0))
    else $error("result sequence does not restart at row 0");

endmodule

bind matrix_vector_multiply_core mvm_checker u_mvm_checker (.*);
